// File: sv/spim_pkg.sv
// Shared types and constants for the SPI mode 0 byte master.
// Depends on nothing; used by every module of the block.
package spim_pkg;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_SELECT   = 2'd1,
    OP_START    = 2'd2,
    OP_DESELECT = 2'd3
  } op_t;

  localparam int unsigned BYTE_BITS = 8;
  localparam logic [15:0] HALF_RESET = 16'd100;
  localparam logic [3:0]  BITS_INIT  = 4'd8;

  // One classified tick as it travels from the front to the back.
  typedef struct packed {
    logic       sel;
    logic       start;
    logic       desel;
    logic       any_cmd;
    logic [7:0] tx_byte;
    logic       miso;
  } cmd_t;

endpackage

// File: sv/spi_master_mode0_byte_top.sv
// Top level of the SPI mode 0 byte master: front end, command queue, back end.
// Depends on spim_pkg, spim_front, spim_fifo and spim_back.
//
// Use: each input beat is one tick of the bit-banged SPI interface. It carries
// an operation (tick only, select, start byte, deselect), the byte to send and
// the sampled MISO level. Each input beat yields exactly one result beat with
// the pin levels (ss_n, SCK, MOSI) and status after that tick: busy, a one-beat
// done pulse with the received byte, and a flag for a command dropped while busy.
// The half period in ticks is written through the cfg_ channel; the user must write
// it only while the block is idle, which the block does not enforce. cfg_ready is
// always high. Zero acts as one. An accepted input beat is first written into the
// queue; the bit engine then pops it and registers its result beat.
// Throughput: one beat per cycle while the result is not stalled; the bit engine
// retires one queued tick each cycle its output register is free.
// Stall: a stalled result holds in the output register while the queue keeps
// taking input beats; in_stall rises only once the FIFO_DEPTH-entry queue is full.
// Reset (synchronous, rst_n low): queue emptied, SCK low, ss_n high, MOSI low,
// no transfer in progress, half period back to 100 ticks.
module spi_master_mode0_byte_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_half_period_ticks,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_miso_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ss_n,
  output logic        out_sck_level,
  output logic        out_mosi_level,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic [7:0]  out_rx_byte,
  output logic        out_cmd_rejected
);

  spim_pkg::cmd_t q_wdata;
  spim_pkg::cmd_t q_rdata;
  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  // the user must send register writes only while idle (not enforced here); take them at once
  assign cfg_ready = 1'b1;

  spim_front u_front (
    .in_valid      (in_valid),
    .in_operation  (in_operation),
    .in_tx_byte    (in_tx_byte),
    .in_miso_level (in_miso_level),
    .q_full        (q_full),
    .in_stall      (in_stall),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  spim_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  spim_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_valid             (cfg_valid),
    .cfg_half_period_ticks (cfg_half_period_ticks),
    .q_rdata               (q_rdata),
    .q_empty               (q_empty),
    .q_pop                 (q_pop),
    .out_stall             (out_stall),
    .out_valid             (out_valid),
    .out_ss_n              (out_ss_n),
    .out_sck_level         (out_sck_level),
    .out_mosi_level        (out_mosi_level),
    .out_busy_res          (out_busy_res),
    .out_done_res          (out_done_res),
    .out_rx_byte           (out_rx_byte),
    .out_cmd_rejected      (out_cmd_rejected)
  );

endmodule

// File: sv/spim_front.sv
// Front end: accept input beats and decode the operation into a command word.
// Depends on spim_pkg.
module spim_front (
  input  logic              in_valid,
  input  logic [1:0]        in_operation,
  input  logic [7:0]        in_tx_byte,
  input  logic              in_miso_level,
  input  logic              q_full,
  output logic              in_stall,
  output logic              q_push,
  output spim_pkg::cmd_t    q_wdata
);

  spim_pkg::op_t op;

  assign op       = spim_pkg::op_t'(in_operation);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_wdata         = '0;
    q_wdata.tx_byte = in_tx_byte;
    q_wdata.miso    = in_miso_level;
    unique case (op)
      spim_pkg::OP_TICK: begin
        q_wdata.any_cmd = 1'b0;
      end
      spim_pkg::OP_SELECT: begin
        q_wdata.sel     = 1'b1;
        q_wdata.any_cmd = 1'b1;
      end
      spim_pkg::OP_START: begin
        q_wdata.start   = 1'b1;
        q_wdata.any_cmd = 1'b1;
      end
      spim_pkg::OP_DESELECT: begin
        q_wdata.desel   = 1'b1;
        q_wdata.any_cmd = 1'b1;
      end
      default: begin
        q_wdata.any_cmd = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/spim_fifo.sv
// Short command queue between front and back end.
// Depends on spim_pkg.
module spim_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spim_pkg::cmd_t    wdata,
  input  logic              pop,
  output spim_pkg::cmd_t    rdata,
  output logic              full,
  output logic              empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  spim_pkg::cmd_t  mem_r [DEPTH];
  logic [PW-1:0]   wptr_r, wptr_nxt;
  logic [PW-1:0]   rptr_r, rptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

// File: sv/spim_back.sv
// Back end: run the SPI bit engine one tick per command and register the result.
// Depends on spim_pkg.
module spim_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [15:0]       cfg_half_period_ticks,
  input  spim_pkg::cmd_t    q_rdata,
  input  logic              q_empty,
  output logic              q_pop,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              out_ss_n,
  output logic              out_sck_level,
  output logic              out_mosi_level,
  output logic              out_busy_res,
  output logic              out_done_res,
  output logic [7:0]        out_rx_byte,
  output logic              out_cmd_rejected
);

  logic [15:0] half_r;
  logic [7:0]  out_shift_r, out_shift_nxt;
  logic [7:0]  in_shift_r, in_shift_nxt;
  logic [3:0]  bits_left_r, bits_left_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic        clock_high_r, clock_high_nxt;
  logic        select_high_r, select_high_nxt;
  logic        mosi_r, mosi_nxt;
  logic        valid_r;
  logic        done_nxt, rej_nxt;
  logic [7:0]  rx_nxt;
  logic [15:0] half_load, timer_dec;
  logic        busy;
  logic [7:0]  shifted;

  assign q_pop     = !q_empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign busy      = (bits_left_r != '0);
  assign half_load = (half_r == '0) ? 16'd1 : half_r;
  assign timer_dec = (timer_r != '0) ? timer_r - 16'd1 : '0;
  assign shifted   = {out_shift_r[6:0], 1'b0};

  always_comb begin
    out_shift_nxt   = out_shift_r;
    in_shift_nxt    = in_shift_r;
    bits_left_nxt   = bits_left_r;
    timer_nxt       = timer_r;
    clock_high_nxt  = clock_high_r;
    select_high_nxt = select_high_r;
    mosi_nxt        = mosi_r;
    done_nxt        = 1'b0;
    rej_nxt         = 1'b0;
    rx_nxt          = '0;
    if (busy) begin
      rej_nxt   = q_rdata.any_cmd;
      timer_nxt = timer_dec;
      if (timer_dec == '0) begin
        if (!clock_high_r) begin
          // rising edge: sample MISO
          clock_high_nxt = 1'b1;
          in_shift_nxt   = {in_shift_r[6:0], q_rdata.miso};
          timer_nxt      = half_load;
        end else begin
          // falling edge: advance to the next bit, or finish the byte after the last
          clock_high_nxt = 1'b0;
          out_shift_nxt  = shifted;
          bits_left_nxt  = bits_left_r - 4'd1;
          if (bits_left_r == 4'd1) begin
            done_nxt  = 1'b1;
            rx_nxt    = in_shift_r;
            timer_nxt = '0;
          end else begin
            mosi_nxt  = shifted[7];
            timer_nxt = half_load;
          end
        end
      end
    end else if (q_rdata.sel) begin
      select_high_nxt = 1'b0;
    end else if (q_rdata.start) begin
      out_shift_nxt  = q_rdata.tx_byte;
      in_shift_nxt   = '0;
      bits_left_nxt  = spim_pkg::BITS_INIT;
      clock_high_nxt = 1'b0;
      mosi_nxt       = q_rdata.tx_byte[spim_pkg::BYTE_BITS-1];
      timer_nxt      = half_load;
    end else if (q_rdata.desel) begin
      clock_high_nxt  = 1'b0;
      select_high_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r        <= spim_pkg::HALF_RESET;
      out_shift_r   <= '0;
      in_shift_r    <= '0;
      bits_left_r   <= '0;
      timer_r       <= '0;
      clock_high_r  <= 1'b0;
      select_high_r <= 1'b1;
      mosi_r        <= 1'b0;
      valid_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        half_r <= cfg_half_period_ticks;
      end
      if (q_pop) begin
        out_shift_r   <= out_shift_nxt;
        in_shift_r    <= in_shift_nxt;
        bits_left_r   <= bits_left_nxt;
        timer_r       <= timer_nxt;
        clock_high_r  <= clock_high_nxt;
        select_high_r <= select_high_nxt;
        mosi_r        <= mosi_nxt;
        valid_r       <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_ss_n         <= select_high_nxt;
      out_sck_level    <= clock_high_nxt;
      out_mosi_level   <= mosi_nxt;
      out_busy_res     <= (bits_left_nxt != '0);
      out_done_res     <= done_nxt;
      out_rx_byte      <= rx_nxt;
      out_cmd_rejected <= rej_nxt;
    end
  end

endmodule
